// ===== rtl/prq_pkg.sv =====
`default_nettype none

package prq_pkg;

   localparam int MAX_THREADS = 32;
   localparam int ADDR_W = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
   localparam int LINK_W = $clog2(MAX_THREADS + 1);
   localparam logic [LINK_W-1:0] LINK_NULL = LINK_W'(MAX_THREADS);

   localparam int CMD_W = 3;
   localparam int ID_W = 5;
   localparam int PRIO_W = 8;
   localparam int STATUS_W = 2;
   localparam int FLAG_W = 3;

   localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
   localparam logic [CMD_W-1:0] CMD_SCHEDULE = 3'd1;
   localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
   localparam logic [CMD_W-1:0] CMD_SET_FLAGS = 3'd3;
   localparam logic [CMD_W-1:0] CMD_YIELD = 3'd4;

   localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_QUEUED = 2'd3;

   localparam logic [FLAG_W-1:0] FLG_QUEUED = 3'b001;
   localparam logic [FLAG_W-1:0] FLG_SUSP = 3'b010;
   localparam logic [FLAG_W-1:0] FLG_JOIN = 3'b100;

   typedef struct packed {
      logic [LINK_W-1:0] link;
      logic [FLAG_W-1:0] flags;
      logic [PRIO_W-1:0] prio;
   } entry_type;

   localparam entry_type RESET_ENTRY = '{link: LINK_NULL, flags: '0, prio: '0};

   typedef struct packed {
      logic en;
      logic [ADDR_W-1:0] addr;
      entry_type data;
   } mem_wr_type;

   typedef struct packed {
      logic [CMD_W-1:0] command;
      logic [ID_W-1:0] thread_id;
      logic [PRIO_W-1:0] priority_req;
      logic suspended;
      logic wait_join;
   } req_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0] chosen_id;
      logic [PRIO_W-1:0] chosen_priority;
      logic chosen_valid;
      logic switch_hint;
   } result_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_CHK,
      ST_INS_WALK,
      ST_INS_LINK,
      ST_INS_PREV,
      ST_SCH_FIND,
      ST_SCH_DROP,
      ST_REM_CHK,
      ST_REM_WALK,
      ST_REM_FIX,
      ST_FLG_WR,
      ST_YLD_HEAD,
      ST_YLD_CUR,
      ST_FINISH
   } state_type;

endpackage

`default_nettype wire

// ===== rtl/prq_ram.sv =====
`default_nettype none

module prq_ram (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire prq_pkg::mem_wr_type         wr,
   input  wire logic [prq_pkg::ADDR_W-1:0]  rd_addr,
   output prq_pkg::entry_type               rd_data
);

   prq_pkg::entry_type entry_mem [prq_pkg::MAX_THREADS];
   prq_pkg::entry_type rd_data_ff;
   logic [prq_pkg::MAX_THREADS-1:0] valid_ff;
   logic rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
         rd_valid_ff <= valid_ff[rd_addr];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : prq_pkg::RESET_ENTRY;

endmodule

`default_nettype wire

// ===== rtl/prq_ctrl.sv =====
`default_nettype none

module prq_ctrl (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   input  wire prq_pkg::req_type            req,
   output logic                             req_ready,
   output logic                             res_valid,
   output prq_pkg::result_type              res,
   input  wire logic                        res_take,
   output logic [prq_pkg::ADDR_W-1:0]       rd_addr,
   input  wire prq_pkg::entry_type          rd_data,
   output prq_pkg::mem_wr_type              wr
);

   prq_pkg::state_type state_ff, state_in;
   prq_pkg::req_type req_ff, req_in;
   logic [prq_pkg::LINK_W-1:0] head_ff, head_in;
   logic [prq_pkg::ADDR_W-1:0] current_ff, current_in;
   logic [prq_pkg::LINK_W-1:0] cur_ff, cur_in;
   logic [prq_pkg::LINK_W-1:0] prev_ff, prev_in;
   logic [prq_pkg::LINK_W-1:0] pick_ff, pick_in;
   prq_pkg::entry_type ent_ff, ent_in;
   prq_pkg::entry_type prev_ent_ff, prev_ent_in;
   prq_pkg::result_type res_ff, res_in;

   logic [prq_pkg::LINK_W-1:0] id_link;
   logic [prq_pkg::ADDR_W-1:0] id_addr;

   function automatic logic in_range(input logic [prq_pkg::ID_W-1:0] id);
      return {{(16 - prq_pkg::ID_W){1'b0}}, id} < 16'(prq_pkg::MAX_THREADS);
   endfunction

   assign id_link = prq_pkg::LINK_W'(req_ff.thread_id);
   assign id_addr = prq_pkg::ADDR_W'(req_ff.thread_id);
   assign res = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= prq_pkg::ST_IDLE;
         head_ff <= prq_pkg::LINK_NULL;
         current_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff <= head_in;
         current_ff <= current_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_in;
      cur_ff <= cur_in;
      prev_ff <= prev_in;
      pick_ff <= pick_in;
      ent_ff <= ent_in;
      prev_ent_ff <= prev_ent_in;
      res_ff <= res_in;
   end

   always_comb begin
      state_in = state_ff;
      req_in = req_ff;
      head_in = head_ff;
      current_in = current_ff;
      cur_in = cur_ff;
      prev_in = prev_ff;
      pick_in = pick_ff;
      ent_in = ent_ff;
      prev_ent_in = prev_ent_ff;
      res_in = res_ff;
      req_ready = 1'b0;
      res_valid = 1'b0;
      rd_addr = '0;
      wr = '0;

      unique case (state_ff)
         prq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               req_in = req;
               res_in = '0;
               unique case (req.command)
                  prq_pkg::CMD_INSERT: begin
                     rd_addr = prq_pkg::ADDR_W'(req.thread_id);
                     if (!in_range(req.thread_id)) begin
                        res_in.status = prq_pkg::STATUS_NOT_FOUND;
                        state_in = prq_pkg::ST_FINISH;
                     end else begin
                        state_in = prq_pkg::ST_INS_CHK;
                     end
                  end
                  prq_pkg::CMD_REMOVE: begin
                     rd_addr = prq_pkg::ADDR_W'(req.thread_id);
                     if (!in_range(req.thread_id)) begin
                        res_in.status = prq_pkg::STATUS_NOT_FOUND;
                        state_in = prq_pkg::ST_FINISH;
                     end else begin
                        state_in = prq_pkg::ST_REM_CHK;
                     end
                  end
                  prq_pkg::CMD_SET_FLAGS: begin
                     rd_addr = prq_pkg::ADDR_W'(req.thread_id);
                     if (!in_range(req.thread_id)) begin
                        res_in.status = prq_pkg::STATUS_NOT_FOUND;
                        state_in = prq_pkg::ST_FINISH;
                     end else begin
                        state_in = prq_pkg::ST_FLG_WR;
                     end
                  end
                  prq_pkg::CMD_SCHEDULE: begin
                     rd_addr = prq_pkg::ADDR_W'(head_ff);
                     cur_in = head_ff;
                     if (head_ff == prq_pkg::LINK_NULL) begin
                        res_in.status = prq_pkg::STATUS_EMPTY;
                        state_in = prq_pkg::ST_FINISH;
                     end else begin
                        state_in = prq_pkg::ST_SCH_FIND;
                     end
                  end
                  prq_pkg::CMD_YIELD: begin
                     rd_addr = prq_pkg::ADDR_W'(head_ff);
                     if (head_ff == prq_pkg::LINK_NULL) begin
                        res_in.status = prq_pkg::STATUS_EMPTY;
                        state_in = prq_pkg::ST_FINISH;
                     end else begin
                        state_in = prq_pkg::ST_YLD_HEAD;
                     end
                  end
                  default: begin
                     state_in = prq_pkg::ST_FINISH;
                  end
               endcase
            end
         end

         prq_pkg::ST_INS_CHK: begin
            if ((rd_data.flags & prq_pkg::FLG_QUEUED) != '0) begin
               res_in.status = prq_pkg::STATUS_QUEUED;
               state_in = prq_pkg::ST_FINISH;
            end else begin
               ent_in = rd_data;
               prev_in = prq_pkg::LINK_NULL;
               cur_in = head_ff;
               rd_addr = prq_pkg::ADDR_W'(head_ff);
               state_in = (head_ff == prq_pkg::LINK_NULL) ? prq_pkg::ST_INS_LINK
                                                         : prq_pkg::ST_INS_WALK;
            end
         end

         prq_pkg::ST_INS_WALK: begin
            if ($signed(rd_data.prio) >= $signed(req_ff.priority_req)) begin
               prev_in = cur_ff;
               prev_ent_in = rd_data;
               cur_in = rd_data.link;
               rd_addr = prq_pkg::ADDR_W'(rd_data.link);
               if (rd_data.link == prq_pkg::LINK_NULL) begin
                  state_in = prq_pkg::ST_INS_LINK;
               end
            end else begin
               state_in = prq_pkg::ST_INS_LINK;
            end
         end

         prq_pkg::ST_INS_LINK: begin
            wr.en = 1'b1;
            wr.addr = id_addr;
            wr.data.link = cur_ff;
            wr.data.flags = ent_ff.flags | prq_pkg::FLG_QUEUED;
            wr.data.prio = req_ff.priority_req;
            if (prev_ff == prq_pkg::LINK_NULL) begin
               head_in = id_link;
               state_in = prq_pkg::ST_FINISH;
            end else begin
               state_in = prq_pkg::ST_INS_PREV;
            end
         end

         prq_pkg::ST_INS_PREV: begin
            wr.en = 1'b1;
            wr.addr = prq_pkg::ADDR_W'(prev_ff);
            wr.data.link = id_link;
            wr.data.flags = prev_ent_ff.flags;
            wr.data.prio = prev_ent_ff.prio;
            state_in = prq_pkg::ST_FINISH;
         end

         prq_pkg::ST_SCH_FIND: begin
            if ((rd_data.flags & (prq_pkg::FLG_SUSP | prq_pkg::FLG_JOIN)) == '0) begin
               pick_in = cur_ff;
               cur_in = head_ff;
               rd_addr = prq_pkg::ADDR_W'(head_ff);
               state_in = prq_pkg::ST_SCH_DROP;
            end else if (rd_data.link == prq_pkg::LINK_NULL) begin
               res_in.status = prq_pkg::STATUS_EMPTY;
               state_in = prq_pkg::ST_FINISH;
            end else begin
               cur_in = rd_data.link;
               rd_addr = prq_pkg::ADDR_W'(rd_data.link);
            end
         end

         prq_pkg::ST_SCH_DROP: begin
            wr.en = 1'b1;
            wr.addr = prq_pkg::ADDR_W'(cur_ff);
            wr.data.link = prq_pkg::LINK_NULL;
            wr.data.flags = rd_data.flags & ~prq_pkg::FLG_QUEUED;
            wr.data.prio = rd_data.prio;
            if (cur_ff == pick_ff) begin
               head_in = rd_data.link;
               current_in = prq_pkg::ADDR_W'(cur_ff);
               res_in.status = prq_pkg::STATUS_OK;
               res_in.chosen_id = prq_pkg::ID_W'(cur_ff);
               res_in.chosen_priority = rd_data.prio;
               res_in.chosen_valid = 1'b1;
               state_in = prq_pkg::ST_FINISH;
            end else begin
               cur_in = rd_data.link;
               rd_addr = prq_pkg::ADDR_W'(rd_data.link);
            end
         end

         prq_pkg::ST_REM_CHK: begin
            ent_in = rd_data;
            if ((rd_data.flags & prq_pkg::FLG_QUEUED) == '0) begin
               res_in.status = prq_pkg::STATUS_NOT_FOUND;
               state_in = prq_pkg::ST_FINISH;
            end else if (head_ff == id_link) begin
               head_in = rd_data.link;
               wr.en = 1'b1;
               wr.addr = id_addr;
               wr.data.link = prq_pkg::LINK_NULL;
               wr.data.flags = rd_data.flags & ~prq_pkg::FLG_QUEUED;
               wr.data.prio = rd_data.prio;
               state_in = prq_pkg::ST_FINISH;
            end else begin
               cur_in = head_ff;
               rd_addr = prq_pkg::ADDR_W'(head_ff);
               state_in = prq_pkg::ST_REM_WALK;
            end
         end

         prq_pkg::ST_REM_WALK: begin
            if (rd_data.link == id_link) begin
               wr.en = 1'b1;
               wr.addr = prq_pkg::ADDR_W'(cur_ff);
               wr.data.link = ent_ff.link;
               wr.data.flags = rd_data.flags;
               wr.data.prio = rd_data.prio;
               state_in = prq_pkg::ST_REM_FIX;
            end else if (rd_data.link == prq_pkg::LINK_NULL) begin
               res_in.status = prq_pkg::STATUS_NOT_FOUND;
               state_in = prq_pkg::ST_FINISH;
            end else begin
               cur_in = rd_data.link;
               rd_addr = prq_pkg::ADDR_W'(rd_data.link);
            end
         end

         prq_pkg::ST_REM_FIX: begin
            wr.en = 1'b1;
            wr.addr = id_addr;
            wr.data.link = prq_pkg::LINK_NULL;
            wr.data.flags = ent_ff.flags & ~prq_pkg::FLG_QUEUED;
            wr.data.prio = ent_ff.prio;
            state_in = prq_pkg::ST_FINISH;
         end

         prq_pkg::ST_FLG_WR: begin
            wr.en = 1'b1;
            wr.addr = id_addr;
            wr.data.link = rd_data.link;
            wr.data.flags = (rd_data.flags & prq_pkg::FLG_QUEUED)
                          | (req_ff.suspended ? prq_pkg::FLG_SUSP : '0)
                          | (req_ff.wait_join ? prq_pkg::FLG_JOIN : '0);
            wr.data.prio = rd_data.prio;
            state_in = prq_pkg::ST_FINISH;
         end

         prq_pkg::ST_YLD_HEAD: begin
            ent_in = rd_data;
            rd_addr = current_ff;
            state_in = prq_pkg::ST_YLD_CUR;
         end

         prq_pkg::ST_YLD_CUR: begin
            res_in.status = prq_pkg::STATUS_OK;
            res_in.chosen_id = prq_pkg::ID_W'(head_ff);
            res_in.chosen_priority = ent_ff.prio;
            res_in.chosen_valid = 1'b1;
            res_in.switch_hint = $signed(ent_ff.prio) >= $signed(rd_data.prio);
            state_in = prq_pkg::ST_FINISH;
         end

         prq_pkg::ST_FINISH: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = prq_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = prq_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/priority_ready_queue_unit.sv =====
// Ready queue of thread ids held as one linked list, sorted by signed priority with the
// highest first and in arrival order among equal priorities. One command is in work at a
// time, and every command gives one result. The per-thread entries live in a memory with
// one read and one write port and a registered read, and the list walk follows
// one link per cycle through that read port. A schedule walks the skipped prefix
// of the list twice. Entry valid bits are cleared at reset, so the block takes
// commands as soon as reset is released. A finished result waits in the output
// register while the next command is accepted.
`default_nettype none

module priority_ready_queue_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // thread_id[4:0], priority_req[12:5], suspended[13], wait_join[14], zero[15]
   input  wire logic [15:0] req_tdata,
   // command[2:0]
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // status[1:0], chosen_id[6:2], chosen_priority[14:7], chosen_valid[15],
   // switch_hint[16], zero[23:17]
   output logic [23:0]      rsp_tdata
);

   prq_pkg::req_type req;
   prq_pkg::result_type ctrl_res;
   prq_pkg::result_type rsp_data_ff;
   logic rsp_valid_ff;
   logic ctrl_res_valid;
   logic res_take;
   logic [prq_pkg::ADDR_W-1:0] rd_addr;
   prq_pkg::entry_type rd_data;
   prq_pkg::mem_wr_type wr;

   assign req.command = req_tuser;
   assign req.thread_id = req_tdata[4:0];
   assign req.priority_req = req_tdata[12:5];
   assign req.suspended = req_tdata[13];
   assign req.wait_join = req_tdata[14];

   assign res_take = ctrl_res_valid && (!rsp_valid_ff || rsp_tready);

   prq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req       (req),
      .req_ready (req_tready),
      .res_valid (ctrl_res_valid),
      .res       (ctrl_res),
      .res_take  (res_take),
      .rd_addr   (rd_addr),
      .rd_data   (rd_data),
      .wr        (wr)
   );

   prq_ram u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr      (wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_take) begin
         rsp_data_ff <= ctrl_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {7'd0, rsp_data_ff.switch_hint, rsp_data_ff.chosen_valid,
                       rsp_data_ff.chosen_priority, rsp_data_ff.chosen_id,
                       rsp_data_ff.status};

endmodule

`default_nettype wire

// ===== rtl/prq_checker.sv =====
`default_nettype none

module prq_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);

   // One command is in work at a time, so a transfer closes the input side.
   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input accepted while a command was in work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result changed");

   a_no_choice_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[15] |-> rsp_tdata[14:2] == 13'd0)
      else $error("chosen fields set without a chosen thread");

   a_hint_needs_head: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[16] |-> rsp_tdata[15] && rsp_tdata[1:0] == prq_pkg::STATUS_OK)
      else $error("switch hint without a valid queue head");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result presented right after reset");

endmodule

bind priority_ready_queue_unit prq_checker u_prq_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
